// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define AST_HOLDS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Condition must never be seen outside reset.
`define AST_NEVER(lbl, clk, rst, cond) \
   `AST_HOLDS(lbl, clk, rst, !(cond))

`endif

// ===== rtl/core/anb_pkg.sv =====
// Package: types, constants and helpers for the aging neighbor table.
package anb_pkg;

   localparam int NUM_SLOTS  = 8;
   localparam int ID_BITS    = 16;
   localparam int PTR_BITS   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int WAIT_BITS  = $clog2(NUM_SLOTS + 1);
   localparam int CNT_BITS   = 4;
   localparam int TICK_BITS  = 8;
   localparam int NODE_BITS  = 16;
   localparam logic [TICK_BITS-1:0] MASK_RESET = 8'h1F;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_TICK   = 1'b1
   } op_type;

   typedef struct packed {
      op_type               operation;
      logic [NODE_BITS-1:0] node_id;
   } req_type;

   typedef struct packed {
      logic [CNT_BITS-1:0] neighbor_count;
      logic                aged_out;
   } rsp_type;

   // Broadcast from the sequencer to the cell row.
   typedef struct packed {
      logic                insert;
      logic                age;
      logic [PTR_BITS-1:0] wp;
      logic [PTR_BITS-1:0] ap;
      logic [ID_BITS-1:0]  id;
   } seq_cmd_type;

   // Per-cell control.
   typedef struct packed {
      logic               insert;
      logic               sel_write;
      logic               sel_age;
      logic [ID_BITS-1:0] id;
   } cell_ctrl_type;

   // Handshake status from the sequencer.
   typedef struct packed {
      logic busy;
      logic rsp_valid;
      logic aged;
   } seq_stat_type;

   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
      if (p == PTR_BITS'(NUM_SLOTS - 1)) begin
         return '0;
      end
      return p + PTR_BITS'(1);
   endfunction

   // Low ID_BITS of the node field, zero extended if ID_BITS is wider.
   function automatic logic [ID_BITS-1:0] fit_id(input logic [NODE_BITS-1:0] v);
      logic [ID_BITS+NODE_BITS-1:0] ext;
      ext = {{ID_BITS{1'b0}}, v};
      return ext[ID_BITS-1:0];
   endfunction

endpackage

// ===== rtl/core/anb_cell.sv =====
// One table slot: holds an ID and adds its occupancy to the running count.
module anb_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  anb_pkg::cell_ctrl_type         ctrl,
   input  logic [anb_pkg::CNT_BITS-1:0]   partial_in,
   output logic [anb_pkg::CNT_BITS-1:0]   partial_out
);
   import anb_pkg::*;

   logic [ID_BITS-1:0]  slot_ff, slot_in;
   logic [CNT_BITS-1:0] partial_ff, partial_in_nxt;
   logic [CNT_BITS:0]   sum;

   always_comb begin
      slot_in = slot_ff;
      if (ctrl.sel_write) begin
         slot_in = ctrl.id;
      end else if (ctrl.insert && (slot_ff == ctrl.id)) begin
         slot_in = '0;          // duplicate of the new entry
      end else if (ctrl.sel_age) begin
         slot_in = '0;
      end
   end

   // saturating count
   always_comb begin
      sum = {1'b0, partial_in} + (CNT_BITS+1)'(slot_ff != '0);
      partial_in_nxt = sum[CNT_BITS] ? {CNT_BITS{1'b1}} : sum[CNT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      partial_ff <= partial_in_nxt;
   end

   assign partial_out = partial_ff;

endmodule

// ===== rtl/core/anb_seq.sv =====
// Sequencer: pointers, tick counter, refresh mask and result timing.
module anb_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  anb_pkg::req_type                req_data,
   input  logic                            csr_we,
   input  logic [anb_pkg::TICK_BITS-1:0]   csr_wdata,
   output anb_pkg::seq_cmd_type            cmd,
   output anb_pkg::seq_stat_type           stat
);
   import anb_pkg::*;

   logic [PTR_BITS-1:0]  wp_ff, wp_in;
   logic [PTR_BITS-1:0]  ap_ff, ap_in;
   logic [TICK_BITS-1:0] tick_ff, tick_in, tick_next;
   logic [TICK_BITS-1:0] mask_ff, mask_in;
   logic [WAIT_BITS-1:0] wait_ff, wait_in;
   logic                 valid_ff, valid_in;
   logic                 aged_ff, aged_in;
   logic                 accept, do_insert, do_age;

   assign accept    = start && (wait_ff == '0);
   assign tick_next = tick_ff + TICK_BITS'(1);

   always_comb begin
      do_insert = 1'b0;
      do_age    = 1'b0;
      tick_in   = tick_ff;
      if (accept) begin
         unique case (req_data.operation)
            OP_INSERT: begin
               do_insert = 1'b1;
            end
            OP_TICK: begin
               tick_in = tick_next;
               do_age  = ((tick_next & mask_ff) == '0);
            end
            default: begin
               do_insert = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      wp_in = do_insert ? next_ptr(wp_ff) : wp_ff;
      ap_in = ((do_insert && (wp_ff == ap_ff)) || do_age) ? next_ptr(ap_ff) : ap_ff;
      mask_in = csr_we ? csr_wdata : mask_ff;
      if (accept) begin
         wait_in = WAIT_BITS'(NUM_SLOTS);
      end else if (wait_ff != '0) begin
         wait_in = wait_ff - WAIT_BITS'(1);
      end else begin
         wait_in = wait_ff;
      end
      valid_in = (wait_ff == WAIT_BITS'(1));
      aged_in  = accept ? do_age : aged_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         ap_ff    <= '0;
         tick_ff  <= '0;
         mask_ff  <= MASK_RESET;
         wait_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         wp_ff    <= wp_in;
         ap_ff    <= ap_in;
         tick_ff  <= tick_in;
         mask_ff  <= mask_in;
         wait_ff  <= wait_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      aged_ff <= aged_in;
   end

   assign cmd.insert = do_insert;
   assign cmd.age    = do_age;
   assign cmd.wp     = wp_ff;
   assign cmd.ap     = ap_ff;
   assign cmd.id     = fit_id(req_data.node_id);

   assign stat.busy      = (wait_ff != '0);
   assign stat.rsp_valid = valid_ff;
   assign stat.aged      = aged_ff;

endmodule

// ===== rtl/core/aging_neighbor_table.sv =====
// Top level: ring table of neighbor IDs with aging, built as a row of slot cells.
//
// Usage:
//  - Request: drive req_data and raise start; the request is taken at a rising
//    edge where start is high and busy is low. operation OP_INSERT writes
//    node_id at the write pointer and clears any other slot with that ID;
//    OP_TICK bumps the tick counter and may age out the slot at the aging pointer.
//  - Result: one per request, shown on rsp_data for exactly one cycle with
//    rsp_valid high. The receiver cannot stall; it must take it in that cycle.
//  - Timing: busy goes high at the accepting edge and drops in the cycle that
//    shows the result, so a new request can be taken at the edge that ends
//    it; no new request is taken before the result of the last one shows.
//  - The timing is set by the occupancy count, which ripples through the cell
//    row one cell per cycle after the table has been updated.
//  - Configuration: csr_we writes csr_wdata to the refresh mask; write only
//    while busy is low and no result is pending.
//  - Reset (synchronous, active high): table empty, both pointers and the tick
//    counter zero, refresh mask 0x1F, busy low, no result pending.
module aging_neighbor_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  anb_pkg::req_type                req_data,
   output logic                            rsp_valid,
   output anb_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [anb_pkg::TICK_BITS-1:0]   csr_wdata
);
   import anb_pkg::*;

   seq_cmd_type         cmd;
   seq_stat_type        stat;
   logic [CNT_BITS-1:0] partial [NUM_SLOTS];

   // pointers, tick counter, mask and result timing
   anb_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Row of slot cells; each one decodes its own select from the pointers,
   // and the occupancy count passes from cell to cell every cycle.
   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      cell_ctrl_type       ctrl;
      logic [CNT_BITS-1:0] chain_in;

      assign ctrl.insert    = cmd.insert;
      assign ctrl.sel_write = cmd.insert && (cmd.wp == PTR_BITS'(i));
      assign ctrl.sel_age   = cmd.age && (cmd.ap == PTR_BITS'(i));
      assign ctrl.id        = cmd.id;

      if (i == 0) begin : g_head
         assign chain_in = '0;
      end else begin : g_link
         assign chain_in = partial[i-1];
      end

      anb_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .partial_in  (chain_in),
         .partial_out (partial[i])
      );
   end

   assign busy                    = stat.busy;
   assign rsp_valid               = stat.rsp_valid;
   assign rsp_data.neighbor_count = partial[NUM_SLOTS-1];
   assign rsp_data.aged_out       = stat.aged;

endmodule

// ===== rtl/core/anb_checker.sv =====
// Port-level checker for the aging neighbor table, bound to the top level.
`include "assert_macros.svh"

module anb_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // a taken request keeps the block busy in the next cycle
   `AST_HOLDS(a_accept_busy, clock, reset, (start && !busy) |=> busy)

   // the result cycle is the first free cycle
   `AST_HOLDS(a_rsp_not_busy, clock, reset, rsp_valid |-> !busy)

   // busy only drops together with a result
   `AST_HOLDS(a_fall_has_rsp, clock, reset, $fell(busy) |-> rsp_valid)

   // a result strobe lasts a single cycle
   `AST_NEVER(a_rsp_single, clock, reset, rsp_valid && $past(rsp_valid))

endmodule

bind aging_neighbor_table anb_checker u_anb_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

// ===== bench/aging_neighbor_table_tb.sv =====
// Self-checking testbench for the aging neighbor table: directed table, then random phases.
module aging_neighbor_table_tb;
   import anb_pkg::*;

   // No progress (no request taken, no result shown) for this many cycles ends the run.
   localparam int STALL_LIMIT = 2000;
   // Cycles to watch after the last result for stray results.
   localparam int TAIL_CYCLES = 24;
   // Cap on the all-ones mask phase while waiting for the tick counter to wrap.
   localparam int WRAP_PHASE_CAP = 400;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_we;
   logic [TICK_BITS-1:0] csr_wdata;

   aging_neighbor_table dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Shadow copy of the table: slots, pointers, tick counter and refresh mask.
   // ---------------------------------------------------------------------------
   logic [ID_BITS-1:0]   shadow_slots [NUM_SLOTS];
   int                   wr_ptr;
   int                   age_ptr;
   logic [TICK_BITS-1:0] tick_cnt;
   logic [TICK_BITS-1:0] mask_shadow;

   // Results still owed by the block, oldest first.
   rsp_type pending_counts [$];

   int mismatch_count;
   int requests_taken;
   int results_checked;
   int ages_predicted;
   int masks_written;

   // Sender burst state: requests left in this burst, and whether gaps are off.
   int burst_left;
   bit quiet_sender;

   function automatic int ring_next(input int p);
      return (p + 1 >= NUM_SLOTS) ? 0 : p + 1;
   endfunction

   // Apply one request to the shadow table and return the result it must give.
   function automatic rsp_type table_step(input req_type r);
      rsp_type            res;
      logic [ID_BITS-1:0] id;
      int                 occupied;
      id = r.node_id[ID_BITS-1:0];
      res.aged_out = 1'b0;
      if (r.operation == OP_INSERT) begin
         shadow_slots[wr_ptr] = id;
         // Drop any older copy of the same ID (a zero insert changes nothing here).
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (i != wr_ptr && shadow_slots[i] == id) begin
               shadow_slots[i] = '0;
            end
         end
         if (wr_ptr == age_ptr) begin
            age_ptr = ring_next(age_ptr);
         end
         wr_ptr = ring_next(wr_ptr);
      end else begin
         tick_cnt = tick_cnt + 1'b1;   // wraps 255 -> 0
         if ((tick_cnt & mask_shadow) == '0) begin
            // Ages the slot even when it is already empty.
            shadow_slots[age_ptr] = '0;
            age_ptr = ring_next(age_ptr);
            res.aged_out = 1'b1;
         end
      end
      occupied = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (shadow_slots[i] != '0) occupied++;
      end
      res.neighbor_count = (occupied > 15) ? 4'd15 : CNT_BITS'(occupied);
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------------
   // Result checker. rsp_valid is a one-cycle strobe; sample at the edge that
   // ends the cycle, where the block's own updates have not landed yet.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_counts.size() == 0) begin
            report_mismatch($sformatf("unexpected result count=%0d aged=%0b",
                                      rsp_data.neighbor_count, rsp_data.aged_out));
         end else begin
            want = pending_counts.pop_front();
            results_checked++;
            if (rsp_data.neighbor_count !== want.neighbor_count) begin
               report_mismatch($sformatf("result %0d: neighbor_count %0d, want %0d",
                                         results_checked, rsp_data.neighbor_count,
                                         want.neighbor_count));
            end
            if (rsp_data.aged_out !== want.aged_out) begin
               report_mismatch($sformatf("result %0d: aged_out %0b, want %0b",
                                         results_checked, rsp_data.aged_out,
                                         want.aged_out));
            end
         end
      end
   end

   // Watchdog: counts cycles with neither a request taken nor a result shown.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid || reset) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_counts.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Sender. Requests go out in bursts; between bursts start drops for a random
   // gap so that gaps land at every point of the result latency.
   // Called at a rising edge; returns at the edge that took the request.
   // ---------------------------------------------------------------------------
   task automatic issue_request(input req_type r, input bit fixed, input rsp_type fixed_rsp,
                                output rsp_type predicted);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = quiet_sender ? 0 : $urandom_range(0, 12);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_data <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      requests_taken++;
      predicted = table_step(r);
      if (predicted.aged_out) ages_predicted++;
      // Directed rows with a hand-written answer check against that instead.
      pending_counts.push_back(fixed ? fixed_rsp : predicted);
   endtask

   // Let the block go idle, then write the refresh mask.
   task automatic set_refresh_mask(input logic [TICK_BITS-1:0] value);
      start <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      mask_shadow = value;
      masks_written++;
   endtask

   // Mostly a small pool of IDs so that duplicates are common, plus zero,
   // the extremes and fully random values.
   function automatic logic [NODE_BITS-1:0] pick_node_id();
      case ($urandom_range(0, 9))
         0:       return '0;
         1: begin
            case ($urandom_range(0, 3))
               0:       return 16'hFFFF;
               1:       return 16'h8000;
               2:       return 16'h0001;
               default: return 16'h7FFF;
            endcase
         end
         2, 3:    return NODE_BITS'($urandom);
         default: return NODE_BITS'($urandom_range(1, 12));
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Directed rows. A row is either a mask write or one request; rows with
   // fixed set carry an answer that can be read straight off the behavior.
   // ---------------------------------------------------------------------------
   typedef struct packed {
      logic                 is_cfg;
      op_type               op;
      logic [NODE_BITS-1:0] id;
      logic [TICK_BITS-1:0] mask;
      logic                 fixed;
      logic [CNT_BITS-1:0]  count;
      logic                 aged;
   } dir_row_type;

   localparam int DIR_ROWS = 19;
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      // tick right after reset: counter 1, mask 0x1F, no aging
      '{1'b0, OP_TICK,   16'hFFFF, 8'h00, 1'b1, 4'd0, 1'b0},
      '{1'b0, OP_INSERT, 16'hFFFF, 8'h00, 1'b1, 4'd1, 1'b0},
      '{1'b0, OP_INSERT, 16'h0001, 8'h00, 1'b1, 4'd2, 1'b0},
      // duplicate: the first copy of 0xFFFF is cleared
      '{1'b0, OP_INSERT, 16'hFFFF, 8'h00, 1'b1, 4'd2, 1'b0},
      // zero insert: slot stays empty, pointers still move
      '{1'b0, OP_INSERT, 16'h0000, 8'h00, 1'b1, 4'd2, 1'b0},
      // zero mask: every tick ages
      '{1'b1, OP_INSERT, 16'h0000, 8'h00, 1'b0, 4'd0, 1'b0},
      // aging pointer sits on an empty slot: still reports aged
      '{1'b0, OP_TICK,   16'h0000, 8'h00, 1'b1, 4'd2, 1'b1},
      '{1'b0, OP_TICK,   16'h0000, 8'h00, 1'b0, 4'd0, 1'b0},
      '{1'b0, OP_INSERT, 16'h8000, 8'h00, 1'b0, 4'd0, 1'b0},
      '{1'b0, OP_INSERT, 16'h7FFF, 8'h00, 1'b0, 4'd0, 1'b0},
      '{1'b0, OP_INSERT, 16'hAAAA, 8'h00, 1'b0, 4'd0, 1'b0},
      // both pointers wrap here
      '{1'b0, OP_INSERT, 16'h5555, 8'h00, 1'b0, 4'd0, 1'b0},
      '{1'b0, OP_INSERT, 16'h1234, 8'h00, 1'b0, 4'd0, 1'b0},
      '{1'b0, OP_TICK,   16'h0000, 8'h00, 1'b0, 4'd0, 1'b0},
      '{1'b0, OP_TICK,   16'hFFFF, 8'h00, 1'b0, 4'd0, 1'b0},
      // all-ones mask: ages only when the counter wraps to zero
      '{1'b1, OP_INSERT, 16'h0000, 8'hFF, 1'b0, 4'd0, 1'b0},
      '{1'b0, OP_TICK,   16'h0000, 8'h00, 1'b0, 4'd0, 1'b0},
      '{1'b0, OP_INSERT, 16'h1234, 8'h00, 1'b0, 4'd0, 1'b0},
      '{1'b0, OP_INSERT, 16'hFFFE, 8'h00, 1'b0, 4'd0, 1'b0}
   };

   // Random phases: mask (or a random one), request count, tick share, gaps off.
   typedef struct packed {
      logic                 rand_mask;
      logic [TICK_BITS-1:0] mask;
      logic [15:0]          items;
      logic [7:0]           tick_pct;
      logic                 quiet;
   } phase_type;

   localparam int NUM_PHASES = 6;
   localparam phase_type PHASES [NUM_PHASES] = '{
      '{1'b0, 8'h00, 16'd60, 8'd40, 1'b0},
      // runs on until the counter has wrapped under the all-ones mask, up to WRAP_PHASE_CAP requests
      '{1'b0, 8'hFF, 16'd80, 8'd90, 1'b0},
      '{1'b0, 8'h01, 16'd60, 8'd50, 1'b1},
      '{1'b0, 8'h80, 16'd40, 8'd70, 1'b0},
      '{1'b1, 8'h00, 16'd40, 8'd55, 1'b0},
      '{1'b1, 8'h00, 16'd40, 8'd30, 1'b0}
   };

   // ---------------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------------
   initial begin
      req_type              r;
      rsp_type              fixed_rsp;
      rsp_type              predicted;
      logic [TICK_BITS-1:0] m;
      int                   n;
      int                   phase_ages;

      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_wdata <= '0;

      for (int i = 0; i < NUM_SLOTS; i++) shadow_slots[i] = '0;
      wr_ptr          = 0;
      age_ptr         = 0;
      tick_cnt        = '0;
      mask_shadow     = MASK_RESET;
      mismatch_count  = 0;
      requests_taken  = 0;
      results_checked = 0;
      ages_predicted  = 0;
      masks_written   = 0;
      burst_left      = 0;
      quiet_sender    = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      for (int k = 0; k < DIR_ROWS; k++) begin
         if (DIRECTED[k].is_cfg) begin
            set_refresh_mask(DIRECTED[k].mask);
         end else begin
            r.operation              = DIRECTED[k].op;
            r.node_id                = DIRECTED[k].id;
            fixed_rsp.neighbor_count = DIRECTED[k].count;
            fixed_rsp.aged_out       = DIRECTED[k].aged;
            issue_request(r, DIRECTED[k].fixed, fixed_rsp, predicted);
         end
      end

      // Random phases, each under its own refresh mask.
      for (int p = 0; p < NUM_PHASES; p++) begin
         m = PHASES[p].rand_mask ? TICK_BITS'($urandom_range(0, 255)) : PHASES[p].mask;
         set_refresh_mask(m);
         quiet_sender = PHASES[p].quiet;
         burst_left   = 0;
         n            = 0;
         phase_ages   = 0;
         while (n < PHASES[p].items ||
                (m == 8'hFF && phase_ages == 0 && n < WRAP_PHASE_CAP)) begin
            r.operation = ($urandom_range(1, 100) <= PHASES[p].tick_pct) ? OP_TICK : OP_INSERT;
            r.node_id   = pick_node_id();
            issue_request(r, 1'b0, '0, predicted);
            if (predicted.aged_out) phase_ages++;
            n++;
         end
      end
      quiet_sender = 1'b0;

      // Drain, then watch a while longer for stray results.
      start <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_counts.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", pending_counts.size()));
      end

      $display("Run covered %0d requests (%0d aging ticks) under %0d refresh-mask settings,",
               requests_taken, ages_predicted, masks_written);
      $display("with %0d results checked and %0d mismatches.", results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
